@@ design/tgrf_pkg.sv @@
// Shared constants, codes, command/status types and offset tables of the tile grid fill engine.
package tgrf_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int CELL_BITS   = 4;
  localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int COORD_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W      = 7;
  localparam int PT_W        = 8;
  localparam int EXT_W       = PT_W + 1;
  localparam int CODE_W      = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int NBR_COUNT   = 8;
  localparam int NBR_IDX_W   = $clog2(NBR_COUNT);
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_NBR   = 2'd3
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_FLOOR   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OUT_DONE = 2'd0,
    OUT_READ = 2'd1,
    OUT_NBR  = 2'd2
  } out_kind_t;

  typedef struct packed {
    logic      in_ready;
    logic      capture;
    logic      decode;
    logic      clear_step;
    logic      write_cell;
    logic      fill_step;
    logic      nbr_step;
    logic      load_out;
    out_kind_t out_kind;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    pt_in;
    logic    fill_empty;
    logic    fill_x_end;
    logic    fill_y_end;
    logic    nbr_final;
    logic    clear_last;
    logic    out_free;
  } dp_status_t;

  // Neighbour order: NW, N, NE, W, E, SW, S, SE
  function automatic logic signed [1:0] nbr_dx(logic [NBR_IDX_W-1:0] i);
    logic signed [1:0] d;
    case (i) inside
      3'd0, 3'd3, 3'd5: d = -2'sd1;
      3'd1, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [1:0] nbr_dy(logic [NBR_IDX_W-1:0] i);
    logic signed [1:0] d;
    case (i) inside
      3'd0, 3'd1, 3'd2: d = -2'sd1;
      3'd3, 3'd4:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

endpackage

@@ design/tgrf_ram.sv @@
// Generic single-port RAM with registered read data.
module tgrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/tgrf_ctrl.sv @@
// Controller state machine: clear sweep, decode and sequencing of each operation.
module tgrf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  tgrf_pkg::dp_status_t stat,
  output tgrf_pkg::dp_cmd_t    cmd
);
  import tgrf_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR  = 9'b000000001,
    ST_IDLE   = 9'b000000010,
    ST_DECODE = 9'b000000100,
    ST_READ   = 9'b000001000,
    ST_RDATA  = 9'b000010000,
    ST_WRITE  = 9'b000100000,
    ST_FILL   = 9'b001000000,
    ST_RESP   = 9'b010000000,
    ST_NBR    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.out_kind = OUT_DONE;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        unique case (stat.op)
          OP_READ:  state_next = stat.pt_in ? ST_READ : ST_RESP;
          OP_WRITE: state_next = stat.pt_in ? ST_WRITE : ST_RESP;
          OP_FILL:  state_next = stat.fill_empty ? ST_RESP : ST_FILL;
          OP_NBR:   state_next = ST_NBR;
          default:  state_next = ST_RESP;
        endcase
      end
      ST_READ: begin
        state_next = ST_RDATA;
      end
      ST_RDATA: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = OUT_READ;
          state_next   = ST_IDLE;
        end
      end
      ST_WRITE: begin
        if (stat.out_free) begin
          cmd.write_cell = 1'b1;
          cmd.load_out   = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_x_end && stat.fill_y_end) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_NBR: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = OUT_NBR;
          cmd.nbr_step = 1'b1;
          if (stat.nbr_final) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ design/tgrf_dp.sv @@
// Datapath: config registers, item capture, address math, fill walker, neighbour list, result register.
module tgrf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  tgrf_pkg::dp_cmd_t                   cmd,
  output tgrf_pkg::dp_status_t                stat,
  input  logic                                cfg_valid,
  input  logic [tgrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tgrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [1:0]                          in_opcode,
  input  logic [tgrf_pkg::IN_DATA_W-1:0]      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tgrf_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_nv,
  output logic                                out_last
);
  import tgrf_pkg::*;

  // Configuration
  logic [SIDE_W-1:0] grid_columns;
  logic [SIDE_W-1:0] grid_rows;
  logic [CODE_W-1:0] floor_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= SIDE_W'(MAX_SIDE);
      grid_rows    <= SIDE_W'(MAX_SIDE);
      floor_code   <= CODE_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLUMNS: grid_columns <= cfg_data;
        CFG_ROWS:    grid_rows    <= cfg_data;
        CFG_FLOOR:   floor_code   <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIDE_W-1:0] used_cols;
  logic [SIDE_W-1:0] used_rows;
  assign used_cols = (grid_columns > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_columns;
  assign used_rows = (grid_rows > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_rows;

  logic signed [EXT_W-1:0] cols_e;
  logic signed [EXT_W-1:0] rows_e;
  assign cols_e = $signed(EXT_W'(used_cols));
  assign rows_e = $signed(EXT_W'(used_rows));

  function automatic logic inside_grid(logic signed [EXT_W-1:0] x, logic signed [EXT_W-1:0] y,
                                       logic signed [EXT_W-1:0] cols,
                                       logic signed [EXT_W-1:0] rows);
    return (x >= 0) && (x < cols) && (y >= 0) && (y < rows);
  endfunction

  // Captured item
  opcode_t                op_q;
  logic signed [PT_W-1:0] x0_q, y0_q, x1_q, y1_q;
  logic [CODE_W-1:0]      code_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode_t'(in_opcode);
      x0_q   <= $signed(in_data[PT_W-1:0]);
      y0_q   <= $signed(in_data[2*PT_W-1:PT_W]);
      x1_q   <= $signed(in_data[3*PT_W-1:2*PT_W]);
      y1_q   <= $signed(in_data[4*PT_W-1:3*PT_W]);
      code_q <= in_data[4*PT_W+CODE_W-1:4*PT_W];
    end
  end

  logic signed [EXT_W-1:0] x0e, y0e, x1p, y1p;
  logic signed [EXT_W-1:0] xs_e, ys_e, xe_e, ye_e;
  logic signed [EXT_W-1:0] xl_e, yl_e;
  logic                    pt_in, fill_empty;

  assign x0e  = EXT_W'(x0_q);
  assign y0e  = EXT_W'(y0_q);
  assign x1p  = EXT_W'(x1_q) + EXT_W'(1);
  assign y1p  = EXT_W'(y1_q) + EXT_W'(1);
  assign xs_e = (x0e < 0) ? '0 : x0e;
  assign ys_e = (y0e < 0) ? '0 : y0e;
  assign xe_e = (x1p < cols_e) ? x1p : cols_e;
  assign ye_e = (y1p < rows_e) ? y1p : rows_e;
  assign xl_e = xe_e - EXT_W'(1);
  assign yl_e = ye_e - EXT_W'(1);
  assign pt_in      = inside_grid(x0e, y0e, cols_e, rows_e);
  assign fill_empty = (xs_e >= xe_e) || (ys_e >= ye_e);

  // Row-major address: y * columns + x, one multiplier shared by point ops and fill start
  localparam int PROD_W = COORD_W + SIDE_W;
  logic [COORD_W-1:0] mul_x, mul_y;
  logic [PROD_W-1:0]  prod;
  logic [ADDR_W-1:0]  start_addr;

  assign mul_x      = (op_q == OP_FILL) ? xs_e[COORD_W-1:0] : x0_q[COORD_W-1:0];
  assign mul_y      = (op_q == OP_FILL) ? ys_e[COORD_W-1:0] : y0_q[COORD_W-1:0];
  assign prod       = PROD_W'(mul_y) * PROD_W'(used_cols);
  assign start_addr = ADDR_W'(prod + PROD_W'(mul_x));

  logic [NBR_COUNT-1:0] nbr_mask;
  always_comb begin
    for (int i = 0; i < NBR_COUNT; i++) begin
      nbr_mask[i] = inside_grid(x0e + EXT_W'(nbr_dx(NBR_IDX_W'(i))),
                                y0e + EXT_W'(nbr_dy(NBR_IDX_W'(i))), cols_e, rows_e);
    end
  end

  // Walk state
  logic [ADDR_W-1:0]    addr_q, row_base_q;
  logic [COORD_W-1:0]   fx_q, fy_q, xs_q, xlast_q, ylast_q;
  logic [NBR_COUNT-1:0] mask_q;
  logic                 miss_q;
  logic [ADDR_W-1:0]    next_row_base;
  logic [NBR_IDX_W-1:0] sel;

  assign next_row_base = row_base_q + ADDR_W'(used_cols);

  always_comb begin
    sel = '0;
    for (int i = NBR_COUNT - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = NBR_IDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      addr_q     <= start_addr;
      row_base_q <= ADDR_W'(prod);
      xs_q       <= xs_e[COORD_W-1:0];
      fx_q       <= xs_e[COORD_W-1:0];
      fy_q       <= ys_e[COORD_W-1:0];
      xlast_q    <= xl_e[COORD_W-1:0];
      ylast_q    <= yl_e[COORD_W-1:0];
      mask_q     <= nbr_mask;
      miss_q     <= ((op_q == OP_READ) || (op_q == OP_WRITE)) && !pt_in;
    end else if (cmd.fill_step) begin
      if (fx_q == xlast_q) begin
        fx_q       <= xs_q;
        fy_q       <= fy_q + COORD_W'(1);
        row_base_q <= next_row_base;
        addr_q     <= next_row_base + ADDR_W'(xs_q);
      end else begin
        fx_q   <= fx_q + COORD_W'(1);
        addr_q <= addr_q + ADDR_W'(1);
      end
    end else if (cmd.nbr_step) begin
      mask_q[sel] <= 1'b0;
    end
  end

  // Clear sweep after reset
  logic [ADDR_W-1:0] clr_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_q <= '0;
    end else if (cmd.clear_step) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Cell store
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [CELL_BITS-1:0] ram_wdata, ram_rdata;

  assign ram_we   = cmd.clear_step | cmd.write_cell | cmd.fill_step;
  assign ram_addr = cmd.clear_step ? clr_q : addr_q;
  always_comb begin
    if (cmd.clear_step)     ram_wdata = '0;
    else if (cmd.fill_step) ram_wdata = CELL_BITS'(floor_code);
    else                    ram_wdata = CELL_BITS'(code_q);
  end

  tgrf_ram #(
    .WIDTH(CELL_BITS),
    .DEPTH(DEPTH)
  ) u_cell_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Result register
  logic                 r_status, r_nv, r_last;
  logic [CODE_W-1:0]    r_code;
  logic [COORD_W-1:0]   r_nx, r_ny;
  logic                 nbr_final;
  logic signed [EXT_W-1:0] nx_e, ny_e;

  assign nbr_final = (mask_q & (mask_q - NBR_COUNT'(1))) == '0;
  assign nx_e      = x0e + EXT_W'(nbr_dx(sel));
  assign ny_e      = y0e + EXT_W'(nbr_dy(sel));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      r_status <= 1'b0;
      r_code   <= '0;
      r_nv     <= 1'b0;
      r_nx     <= '0;
      r_ny     <= '0;
      r_last   <= 1'b1;
      case (cmd.out_kind)
        OUT_READ: r_code <= CODE_W'(ram_rdata);
        OUT_NBR: begin
          if (mask_q != '0) begin
            r_nv   <= 1'b1;
            r_nx   <= nx_e[COORD_W-1:0];
            r_ny   <= ny_e[COORD_W-1:0];
            r_last <= nbr_final;
          end
        end
        default: r_status <= miss_q;
      endcase
    end
  end

  assign out_data = {(OUT_DATA_W - 1 - CODE_W - 2*COORD_W)'(0), r_ny, r_nx, r_code, r_status};
  assign out_nv   = r_nv;
  assign out_last = r_last;

  // Status to controller
  assign stat.op         = op_q;
  assign stat.pt_in      = pt_in;
  assign stat.fill_empty = fill_empty;
  assign stat.fill_x_end = (fx_q == xlast_q);
  assign stat.fill_y_end = (fy_q == ylast_q);
  assign stat.nbr_final  = nbr_final;
  assign stat.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
  assign stat.out_free   = !out_valid || out_ready;

endmodule

@@ design/tile_grid_rect_fill_engine_top.sv @@
// Top level of the tile grid rectangle fill engine: controller, datapath and cell store.
//
//  Channel    Dir  Beat when                  Carries
//  s_axis     in   s_axis_tvalid&tready       tuser: opcode; tdata: points, rectangle, code
//  m_axis     out  m_axis_tvalid&tready       tdata: status, read code, neighbour x/y;
//                                             tuser: neighbour valid; tlast: final result
//  cfg        in   cfg_valid&cfg_ready        cfg_index selects register, cfg_data value
//
// Each item runs idle, decode, then: write: write; read: read (a wait on the registered
// cell store read), read data; read or write off the grid: response; fill: fill (one store
// write per covered cell), response; neighbour query: neighbour, one result beat per
// neighbour (at least one), one beat per cycle while the result register is free.
// After rst the cell store is swept to zero, one cell per cycle, with s_axis_tready low;
// cfg writes are taken at any time (cfg_ready is always high).
// One result register sits on m_axis: the next item is accepted while a result waits,
// and the engine stalls only when it needs to load a new result into a full register.
module tile_grid_rect_fill_engine_top (
  input  logic                                clk,
  input  logic                                rst,
  // input item stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] first_x, [15:8] first_y, [23:16] second_x, [31:24] second_y,
  // [35:32] cell_code, [39:36] zero
  input  logic [tgrf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]                          s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] status, [4:1] read_code, [10:5] neighbour_x, [16:11] neighbour_y, [23:17] zero
  output logic [tgrf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] neighbour_valid
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgrf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tgrf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tgrf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  tgrf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .stat    (stat),
    .cmd     (cmd)
  );

  tgrf_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_opcode(s_axis_tuser),
    .in_data  (s_axis_tdata),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_nv   (m_axis_tuser),
    .out_last (m_axis_tlast)
  );

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> stat.out_free)
    else $error("result register overwritten while full");

  // Only one source drives the cell store write port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.write_cell, cmd.fill_step}))
    else $error("cell store write sources collide");

  // Every accepted beat is decoded in the following cycle
  a_decode_follows: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> cmd.decode)
    else $error("accepted beat not decoded");

  // The fill walker never runs on an empty clipped rectangle
  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> !stat.fill_empty)
    else $error("fill step on empty rectangle");

endmodule
